FILE: src/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// types and constants shared by the quoted-printable encoder modules
// ----------------------------------------------------------------------------
package qpe_pkg;

   localparam logic [7:0] CHAR_PRINT_LO  = 8'h21;
   localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] MAX_LINE_RESET = 8'd76;
   localparam logic [7:0] BREAK_MARGIN   = 8'd3;
   localparam logic [8:0] ESC_COST       = 9'd3;
   localparam logic [8:0] PLAIN_COST     = 9'd1;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_HEX_HI,
      PH_HEX_LO,
      PH_BRK_EQ,
      PH_BRK_CR,
      PH_BRK_LF
   } qpe_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       escape;
      logic       soft_break;
      logic       eom;
   } qpe_desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

FILE: src/qpe_if.sv
// ----------------------------------------------------------------------------
// qpe request and response channels
// valid/ready channels carrying raw bytes in and encoded characters out
// ----------------------------------------------------------------------------
interface qpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;

   modport source (output valid, output in_byte, output end_of_message, input ready);
   modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface qpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       message_last;

   modport source (output valid, output out_char, output run_last, output message_last,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_last,
                   output ready);
endinterface

FILE: src/qpe_front.sv
// ----------------------------------------------------------------------------
// qpe_front
// accepts requests, classifies each byte and tracks the line count
// ----------------------------------------------------------------------------
module qpe_front
   import qpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   qpe_req_if.sink      req,
   input  logic         q_full,
   output logic         q_push,
   output qpe_desc_type q_data
);

   logic [7:0] max_line_ff;
   logic [7:0] max_line_in;
   logic [7:0] line_count_ff;
   logic [7:0] line_count_in;
   logic [7:0] threshold;
   logic [8:0] count_sum;
   logic       escape;
   logic       soft_break;

   always_comb begin
      escape = !((req.in_byte >= CHAR_PRINT_LO) && (req.in_byte <= CHAR_PRINT_HI) &&
                 (req.in_byte != CHAR_EQUALS));
      threshold  = (max_line_ff > BREAK_MARGIN) ? (max_line_ff - BREAK_MARGIN) : 8'd0;
      count_sum  = {1'b0, line_count_ff} + (escape ? ESC_COST : PLAIN_COST);
      soft_break = (count_sum >= {1'b0, threshold});
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign q_data    = '{data: req.in_byte, escape: escape, soft_break: soft_break,
                        eom: req.end_of_message};

   always_comb begin
      max_line_in   = csr_we ? csr_wdata : max_line_ff;
      line_count_in = line_count_ff;
      if (q_push) begin
         line_count_in = (soft_break || req.end_of_message) ? 8'd0 : count_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff   <= MAX_LINE_RESET;
         line_count_ff <= 8'd0;
      end else begin
         max_line_ff   <= max_line_in;
         line_count_ff <= line_count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      line_count_ff != 8'hFF)
      else $error("line count out of range");

endmodule

FILE: src/qpe_fifo.sv
// ----------------------------------------------------------------------------
// qpe_fifo
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module qpe_fifo
   import qpe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  qpe_desc_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output qpe_desc_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qpe_desc_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_le_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule

FILE: src/qpe_back.sv
// ----------------------------------------------------------------------------
// qpe_back
// expands each queued request into characters, one per cycle while the response side accepts them
// ----------------------------------------------------------------------------
module qpe_back
   import qpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  qpe_desc_type q_data,
   output logic         q_pop,
   qpe_rsp_if.source    rsp
);

   qpe_phase_type      phase_ff, phase_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               run_last_ff, run_last_in;
   logic               msg_last_ff, msg_last_in;
   logic               load;
   logic               data_done;
   logic               item_done;

   assign load = q_not_empty && (!valid_ff || rsp.ready);

   always_comb begin
      data_done = q_data.escape ? (phase_ff == PH_HEX_LO) : (phase_ff == PH_HEAD);
      item_done = (phase_ff == PH_BRK_LF) || (data_done && !q_data.soft_break);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (load) begin
         priority if (item_done) begin
            phase_in = PH_HEAD;
         end else if (data_done) begin
            phase_in = PH_BRK_EQ;
         end else begin
            unique case (phase_ff)
               PH_HEAD:   phase_in = PH_HEX_HI;
               PH_HEX_HI: phase_in = PH_HEX_LO;
               PH_BRK_EQ: phase_in = PH_BRK_CR;
               PH_BRK_CR: phase_in = PH_BRK_LF;
               default:   phase_in = PH_HEAD;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      unique case (phase_ff)
         PH_HEAD:   char_in = q_data.escape ? CHAR_EQUALS : q_data.data;
         PH_HEX_HI: char_in = hex_char(q_data.data[7:4]);
         PH_HEX_LO: char_in = hex_char(q_data.data[3:0]);
         PH_BRK_EQ: char_in = CHAR_EQUALS;
         PH_BRK_CR: char_in = CHAR_CR;
         PH_BRK_LF: char_in = CHAR_LF;
         default:   char_in = CHAR_EQUALS;
      endcase
      run_last_in = item_done;
      msg_last_in = item_done && q_data.eom;
      q_pop       = load && item_done;
      valid_in    = load || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         msg_last_ff <= msg_last_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_char     = char_ff;
   assign rsp.run_last     = run_last_ff;
   assign rsp.message_last = msg_last_ff;

   a_msg_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && msg_last_ff) |-> run_last_ff)
      else $error("message end not on run end");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_BRK_LF)
      else $error("phase out of range");

endmodule

FILE: src/quoted_printable_encoder_top.sv
// ----------------------------------------------------------------------------
// quoted_printable_encoder_top
// Encodes one raw byte per request into quoted-printable text, one character
// per response. A byte from 0x21 to 0x7E other than '=' gives 1 character,
// any other byte gives '=' and two uppercase hex digits, and a soft break
// '=' CR LF follows when the line count reaches max_line minus 3, so one
// request yields 1, 3, 4 or 6 characters. The back end emits one character
// per clock while the response receiver is ready; the front end accepts
// requests back to back while the queue between the two has room, and a
// full response register does not stop it. The user must write max_line
// through csr_we/csr_wdata only while the block is idle; the block does not
// enforce this. max_line resets to 76.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_top
   import qpe_pkg::*;
#(
   parameter int FIFO_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   qpe_req_if.sink    req,
   qpe_rsp_if.source  rsp
);

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_not_empty;
   qpe_desc_type q_wdata;
   qpe_desc_type q_rdata;

   qpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   qpe_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   qpe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule
